// ===== hdl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// shared constants and the exponent bit table for the softmax engine
// ----------------------------------------------------------------------------
package smx_pkg;
  localparam int MaxLenDef = 64;
  localparam int ExpBits   = 12;

  function automatic logic [31:0] exp_k(input logic [3:0] b);
    case (b)
      4'd0:    exp_k = 32'd4278222805;
      4'd1:    exp_k = 32'd4261543595;
      4'd2:    exp_k = 32'd4228380000;
      4'd3:    exp_k = 32'd4162825044;
      4'd4:    exp_k = 32'd4034748382;
      4'd5:    exp_k = 32'd3790295335;
      4'd6:    exp_k = 32'd3344923893;
      4'd7:    exp_k = 32'd2605029347;
      4'd8:    exp_k = 32'd1580030169;
      4'd9:    exp_k = 32'd581260615;
      4'd10:   exp_k = 32'd78665070;
      4'd11:   exp_k = 32'd1440801;
      default: exp_k = 32'd0;
    endcase
  endfunction

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_RD    = 7'b0000010,
    ST_EXP   = 7'b0000100,
    ST_EFIN  = 7'b0001000,
    ST_NRD   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;
endpackage

// ===== hdl/softmax_vector_engine_top.sv =====
// after the last word each element gets its weight from a read, the exponent
// bit steps (cut short when it lies 16 or more below the maximum) and a finish
// step, then its share from the weight read, the divide steps and a load into
// the output register; loading accepts one word per cycle while no held result
// is stalled; rst_n is synchronous and active low and returns count, maximum,
// sum and flags to their empty state
// ----------------------------------------------------------------------------
// softmax_vector_engine_top
// max-subtracted softmax over a stored vector with a shared multiply and
// a shared shift-subtract divider driven by a small sequencer
// ----------------------------------------------------------------------------
module softmax_vector_engine_top
  import smx_pkg::*;
#(
  parameter int MAX_LEN = MaxLenDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [15:0] out_prob,
  output logic               out_last_out,
  output logic               out_overflow
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  // element and weight memories
  logic [15:0] elem_mem [MAX_LEN];
  logic [15:0] exp_mem  [MAX_LEN];
  logic [15:0] elem_rd_r, exp_rd_r;

  state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic signed [15:0] max_r, max_nxt;
  logic [22:0] sum_r, sum_nxt;
  logic drop_r, drop_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [32:0] acc_r, acc_nxt;
  // divider: 40-bit numerator, one quotient bit per cycle
  logic [39:0] num_r, num_nxt;
  logic [22:0] rem_r, rem_nxt;
  logic [5:0]  dstep_r, dstep_nxt;
  logic [15:0] prob_r, prob_nxt;
  logic lastq_r, lastq_nxt;
  logic ovf_r, ovf_nxt;
  logic ovalid_r, ovalid_nxt;

  logic        acc_w;
  logic [64:0] prod;
  logic [23:0] rem_sh;
  logic [16:0] e_rnd;
  logic [15:0] e_val;
  logic        mem_we, exp_we;
  logic [AW-1:0] rd_addr;
  logic signed [16:0] diff;

  assign in_stall     = (st_r != ST_LOAD) || (ovalid_r && out_stall);
  assign acc_w        = in_valid && !in_stall;
  assign out_valid    = ovalid_r;
  assign out_prob     = prob_r;
  assign out_last_out = lastq_r;
  assign out_overflow = ovf_r;

  assign prod   = acc_r * {1'b0, exp_k(bit_r)};
  assign rem_sh = {rem_r, num_r[39]};
  assign e_rnd  = 17'((acc_r + 33'd32768) >> 16);
  assign e_val  = e_rnd[16] ? 16'hFFFF : e_rnd[15:0];
  assign diff   = 17'(max_r) - 17'(signed'(elem_rd_r));
  assign mem_we = acc_w && (cnt_r < CW'(MAX_LEN));
  assign exp_we = (st_r == ST_EFIN);
  assign rd_addr = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) elem_mem[cnt_r[AW-1:0]] <= in_value;
    if (exp_we) exp_mem[rd_addr] <= e_val;
    elem_rd_r <= elem_mem[rd_addr];
    exp_rd_r  <= exp_mem[rd_addr];
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; idx_nxt = idx_r; max_nxt = max_r;
    sum_nxt = sum_r; drop_nxt = drop_r; dist_nxt = dist_r; bit_nxt = bit_r;
    acc_nxt = acc_r; num_nxt = num_r; rem_nxt = rem_r; dstep_nxt = dstep_r;
    prob_nxt = prob_r; lastq_nxt = lastq_r; ovf_nxt = ovf_r;
    ovalid_nxt = ovalid_r && out_stall;
    case (st_r)
      ST_LOAD: begin
        if (acc_w) begin
          if (cnt_r < CW'(MAX_LEN)) begin
            cnt_nxt = cnt_r + 1'b1;
            if (in_value > max_r) max_nxt = in_value;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            idx_nxt = '0;
            sum_nxt = '0;
            st_nxt  = ST_RD;
          end
        end
      end
      ST_RD: begin
        // wait for the element read
        bit_nxt = '0;
        acc_nxt = 33'h1_0000_0000;
        st_nxt  = ST_EXP;
      end
      ST_EXP: begin
        if (bit_r == 4'd0) dist_nxt = diff[15:0];
        if (bit_r == 4'd0 && diff[15:12] != 4'd0) begin
          acc_nxt = '0;
          st_nxt  = ST_EFIN;
        end else begin
          if ((bit_r == 4'd0) ? diff[0] : dist_r[bit_r]) begin
            acc_nxt = 33'((prod + 65'h8000_0000) >> 32);
          end
          if (bit_r == 4'(ExpBits - 1)) st_nxt = ST_EFIN;
          else bit_nxt = bit_r + 1'b1;
        end
      end
      ST_EFIN: begin
        sum_nxt = sum_r + 23'(e_val);
        if (idx_r + 1'b1 >= cnt_r) begin
          idx_nxt = '0;
          st_nxt  = ST_NRD;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt  = ST_RD;
        end
      end
      ST_NRD: begin
        // numerator is formed once the weight read lands
        if (dstep_r == 6'd0) begin
          dstep_nxt = 6'd1;
        end else begin
          num_nxt   = {8'd0, exp_rd_r, 16'd0} + 40'(sum_r >> 1);
          rem_nxt   = '0;
          dstep_nxt = '0;
          st_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, sum_r}) begin
          rem_nxt = 23'(rem_sh - {1'b0, sum_r});
          num_nxt = {num_r[38:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[22:0];
          num_nxt = {num_r[38:0], 1'b0};
        end
        dstep_nxt = dstep_r + 1'b1;
        if (dstep_r == 6'd39) begin
          dstep_nxt = '0;
          st_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          prob_nxt   = (sum_r == '0) ? 16'd0 :
                       (num_r[39:16] != '0) ? 16'hFFFF : num_r[15:0];
          lastq_nxt  = (idx_r + 1'b1 >= cnt_r);
          ovf_nxt    = drop_r;
          if (idx_r + 1'b1 >= cnt_r) begin
            st_nxt   = ST_LOAD;
            cnt_nxt  = '0;
            max_nxt  = 16'sh8000;
            sum_nxt  = '0;
            drop_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt  = ST_NRD;
          end
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD; cnt_r <= '0; idx_r <= '0; max_r <= 16'sh8000;
      sum_r <= '0; drop_r <= 1'b0; ovalid_r <= 1'b0; dstep_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; idx_r <= idx_nxt; max_r <= max_nxt;
      sum_r <= sum_nxt; drop_r <= drop_nxt; ovalid_r <= ovalid_nxt;
      dstep_r <= dstep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt; bit_r <= bit_nxt; acc_r <= acc_nxt;
    num_r <= num_nxt; rem_r <= rem_nxt; prob_r <= prob_nxt;
    lastq_r <= lastq_nxt; ovf_r <= ovf_nxt;
  end

`ifndef SYNTHESIS
  // one-hot sequencer
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  // count never passes the store depth
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(MAX_LEN))
    else $error("count overrun");
  // a held result word does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_prob) && $stable(out_last_out))
    else $error("result changed while stalled");
`endif
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking softmax bench: directed table vectors, full and overflowing
// vectors, then random ones, all checked by an in-bench fixed-point predictor
// ----------------------------------------------------------------------------
module tb;
  import smx_pkg::*;

  localparam int VecMax = 64;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_value = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic        [15:0] out_prob;
  logic               out_last_out;
  logic               out_overflow;

  softmax_vector_engine_top uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one expected result word
  typedef struct packed {
    logic [15:0] prob;
    logic        last_out;
    logic        overflow;
  } share_t;

  // directed row: element, last flag, optional typed-in share of one-element
  // vectors (a lone element always gets the whole weight)
  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
    logic               known;
    logic [15:0]        prob;
  } row_t;

  share_t      share_q[$];
  logic [15:0] vec_elems[VecMax];
  int          vec_len = 0;
  logic signed [15:0] vec_max = 16'sh8000;
  logic        vec_dropped = 1'b0;
  int          errors = 0;
  bit          stim_done = 1'b0;

  // exponent table, own copy
  localparam logic [31:0] WeightK[12] = '{
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801};

  // weight of distance d (units of 1/256) below the maximum
  function automatic logic [15:0] exp_weight(input logic [16:0] d);
    logic [63:0] acc;
    logic [63:0] w;
    acc = 64'h1_0000_0000;
    if (d >= 17'd4096) return 16'd0;
    for (int b = 0; b < 12; b++)
      if (d[b]) acc = (acc * WeightK[b] + 64'h8000_0000) >> 32;
    w = (acc + 64'd32768) >> 16;
    return (w > 64'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  // accumulate one accepted element; on last, push the vector's shares
  task automatic predict_softmax(input logic signed [15:0] v, input logic lst);
    logic [15:0] wts[VecMax];
    logic [22:0] total;
    logic [63:0] p;
    if (vec_len < VecMax) begin
      vec_elems[vec_len] = v;
      vec_len++;
      if (v > vec_max) vec_max = v;
    end else begin
      vec_dropped = 1'b1;
    end
    if (!lst) return;
    total = '0;
    for (int i = 0; i < vec_len; i++) begin
      wts[i] = exp_weight(17'($signed({vec_max[15], vec_max})
                          - $signed({vec_elems[i][15], vec_elems[i]})));
      total = total + wts[i];
    end
    for (int i = 0; i < vec_len; i++) begin
      p = 0;
      if (total != 0) begin
        p = ((64'(wts[i]) << 16) + (total >> 1)) / total;
        if (p > 64'd65535) p = 64'd65535;
      end
      share_q.push_back('{p[15:0], (i == vec_len - 1), vec_dropped});
    end
    vec_len = 0;
    vec_max = 16'sh8000;
    vec_dropped = 1'b0;
  endtask

  // random gap length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one word and wait for its acceptance
  task automatic send_word(input logic signed [15:0] v, input logic lst);
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= lst;
    do @(posedge clk); while (in_stall);
    predict_softmax(v, lst);
  endtask

  task automatic send_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      in_value <= 16'($urandom);
      repeat (g) @(posedge clk);
    end
  endtask

  // pick near a base so weights stay nonzero, sometimes anywhere or an extreme
  function automatic logic [15:0] rand_elem(input logic signed [15:0] base);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'($urandom);
    if (r < 3) return (r == 2 && $urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
    return 16'(base + $signed(17'($urandom_range(0, 3000)) - 17'sd1500));
  endfunction

  // directed table
  row_t dir_rows[] = '{
    '{16'sh0000, 1'b1, 1'b1, 16'hFFFF},   // lone zero
    '{16'sh7FFF, 1'b1, 1'b1, 16'hFFFF},   // lone maximum
    '{16'sh8000, 1'b1, 1'b1, 16'hFFFF},   // lone minimum
    '{16'sh8000, 1'b0, 1'b0, 16'h0},      // extremes together: min gets zero
    '{16'sh7FFF, 1'b1, 1'b0, 16'h0},
    '{16'sh0100, 1'b0, 1'b0, 16'h0},      // equal elements split evenly
    '{16'sh0100, 1'b1, 1'b0, 16'h0},
    '{16'sh0000, 1'b0, 1'b0, 16'h0},      // one unit apart
    '{16'sh0100, 1'b0, 1'b0, 16'h0},
    '{16'sh0A00, 1'b0, 1'b0, 16'h0},      // just past weight cutoff
    '{16'sh1A01, 1'b1, 1'b0, 16'h0},
    '{16'shFFFF, 1'b0, 1'b0, 16'h0},      // negative mix, all bits set
    '{16'sh5555, 1'b0, 1'b0, 16'h0},
    '{16'shAAAA, 1'b0, 1'b0, 16'h0},
    '{16'sh0001, 1'b1, 1'b0, 16'h0}
  };

  // sender
  initial begin
    int len;
    logic signed [15:0] base;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_word(dir_rows[k].value, dir_rows[k].last);
      if (dir_rows[k].known && share_q.size() > 0)
        share_q[share_q.size() - 1].prob = dir_rows[k].prob;
      send_gap();
    end

    // full vector of max length, then one that overflows and drops its last three
    for (int i = 0; i < VecMax; i++) send_word(16'(i * 37), i == VecMax - 1);
    for (int i = 0; i < VecMax + 3; i++) begin
      send_word(rand_elem(16'sh0200), i == VecMax + 2);
      if (i % 9 == 0) send_gap();
    end

    // random vectors, mostly short
    for (int items = 0; items < 75; ) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
        send_word(rand_elem(base), i == len - 1);
        send_gap();
      end
      items += len;
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall, random with quiet stretches
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        out_stall <= (g > 0);
        repeat (g) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    share_t got;
    share_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_prob, out_last_out, out_overflow};
      if (share_q.size() == 0) begin
        $display("%0t: unexpected word prob=%0d last=%0b ovf=%0b",
                 $time, got.prob, got.last_out, got.overflow);
        errors++;
      end else begin
        want = share_q.pop_front();
        if (got.prob !== want.prob) begin
          $display("%0t: prob expected %0d actual %0d", $time, want.prob, got.prob);
          errors++;
        end
        if (got.last_out !== want.last_out) begin
          $display("%0t: last_out expected %0b actual %0b",
                   $time, want.last_out, got.last_out);
          errors++;
        end
        if (got.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b actual %0b",
                   $time, want.overflow, got.overflow);
          errors++;
        end
      end
    end
  end

  // end of run: drain, then settle
  initial begin
    wait (stim_done);
    wait (share_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // hard limit
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/smx_pkg.sv
hdl/softmax_vector_engine_top.sv
tb/sv/tb.sv
